// File: hw/rtl/laqs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package laqs_pkg;

    // Fixed widths of the request and result fields.
    localparam int WORD_W = 32;
    localparam int SLOT_W = 6;

    // Request codes.
    typedef enum logic [1:0] {
        REQ_INSERT  = 2'd0,
        REQ_DELETE  = 2'd1,
        REQ_SEARCH  = 2'd2,
        REQ_DISPLAY = 2'd3
    } req_t;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_OVERFLOW  = 3'd1,
        ST_UNDERFLOW = 3'd2,
        ST_FOUND     = 3'd3,
        ST_NOTFOUND  = 3'd4
    } status_t;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_DEL   = 2'd1,
        S_WALK  = 2'd2,
        S_FLUSH = 2'd3
    } state_t;

endpackage

`default_nettype wire

// File: hw/rtl/linear_array_queue_with_search_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Insert, overflow and underflow results appear in the cycle after the request; a delete
// result passes through the memory read register and then the output register. A display
// or search walks the live entries through the single read port of the entry memory,
// which delivers one entry per cycle unless out_ready holds it; results stall with out_ready.
// One request is in service at a time. Reset clears head, tail and all control state at once;
// the entry memory is not cleared, so no clearing pass is needed after reset.
module linear_array_queue_with_search_core #(
    parameter int DEPTH = 64
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [1:0]                         req_type,
    input  wire logic signed [laqs_pkg::WORD_W-1:0] word_in,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [2:0]                              status,
    output logic signed [laqs_pkg::WORD_W-1:0]      word_out,
    output logic [laqs_pkg::SLOT_W-1:0]             slot,
    output logic                                    last
);

    // AW addresses one slot; CW counts from zero up to DEPTH itself.
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    // Queue pointers. The queue is empty when head equals tail.
    logic [CW-1:0] head_reg, head_next;
    logic [CW-1:0] tail_reg, tail_next;

    laqs_pkg::state_t state_reg, state_next;
    laqs_pkg::req_t   op_reg, op_next;
    logic signed [laqs_pkg::WORD_W-1:0] key_reg, key_next;

    // Walk pointer: the next slot whose read is to be issued, and the slot whose word
    // the memory read register currently holds.
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] data_idx_reg, data_idx_next;
    logic          data_vld_reg, data_vld_next;

    // A search holds back its latest match, because whether it is the final one is known
    // only when the walk reaches the tail.
    logic          pend_vld_reg, pend_vld_next;
    logic [CW-1:0] pend_slot_reg, pend_slot_next;

    // Output register.
    logic                               out_valid_reg, out_valid_next;
    laqs_pkg::status_t                  status_reg, status_next;
    logic signed [laqs_pkg::WORD_W-1:0] word_reg, word_next;
    logic [laqs_pkg::SLOT_W-1:0]        slot_reg, slot_next;
    logic                               last_reg, last_next;

    // Entry memory with a registered read port.
    logic signed [laqs_pkg::WORD_W-1:0] mem [DEPTH];
    logic signed [laqs_pkg::WORD_W-1:0] rd_data_reg;
    logic                               wr_en;
    logic [AW-1:0]                      wr_addr;
    logic                               rd_en;
    logic [AW-1:0]                      rd_addr;

    logic out_free;
    logic accept;
    logic empty;
    logic consume;
    logic issue;
    logic emit;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == laqs_pkg::S_IDLE) && out_free;
    assign accept   = in_valid && in_ready;
    assign empty    = (head_reg >= tail_reg);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= word_in;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        idx_next       = idx_reg;
        data_idx_next  = data_idx_reg;
        data_vld_next  = data_vld_reg;
        pend_vld_next  = pend_vld_reg;
        pend_slot_next = pend_slot_reg;
        status_next    = status_reg;
        word_next      = word_reg;
        slot_next      = slot_reg;
        last_next      = last_reg;
        wr_en          = 1'b0;
        wr_addr        = tail_reg[AW-1:0];
        rd_en          = 1'b0;
        rd_addr        = idx_reg[AW-1:0];
        consume        = 1'b0;
        issue          = 1'b0;
        emit           = 1'b0;

        case (state_reg)
            laqs_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    op_next  = laqs_pkg::req_t'(req_type);
                    key_next = word_in;
                    if (laqs_pkg::req_t'(req_type) == laqs_pkg::REQ_INSERT)
                    begin
                        emit      = 1'b1;
                        word_next = '0;
                        slot_next = '0;
                        last_next = 1'b1;
                        if (tail_reg == DEPTH_C)
                        begin
                            status_next = laqs_pkg::ST_OVERFLOW;
                        end
                        else
                        begin
                            wr_en       = 1'b1;
                            tail_next   = tail_reg + CW'(1);
                            status_next = laqs_pkg::ST_OK;
                        end
                    end
                    else if (empty)
                    begin
                        emit        = 1'b1;
                        status_next = laqs_pkg::ST_UNDERFLOW;
                        word_next   = '0;
                        slot_next   = '0;
                        last_next   = 1'b1;
                    end
                    else if (laqs_pkg::req_t'(req_type) == laqs_pkg::REQ_DELETE)
                    begin
                        // Read the head slot now; the word is in the read register next cycle.
                        rd_en      = 1'b1;
                        rd_addr    = head_reg[AW-1:0];
                        state_next = laqs_pkg::S_DEL;
                    end
                    else
                    begin
                        idx_next      = head_reg;
                        data_vld_next = 1'b0;
                        pend_vld_next = 1'b0;
                        state_next    = laqs_pkg::S_WALK;
                    end
                end
            end

            laqs_pkg::S_DEL:
            begin
                // The output register was free at accept and nothing has been shown since.
                emit        = 1'b1;
                status_next = laqs_pkg::ST_OK;
                word_next   = rd_data_reg;
                slot_next   = laqs_pkg::SLOT_W'(head_reg);
                last_next   = 1'b1;
                head_next   = head_reg + CW'(1);
                state_next  = laqs_pkg::S_IDLE;
            end

            laqs_pkg::S_WALK:
            begin
                // Retire the word in the read register once the output side can take a result.
                consume = data_vld_reg && out_free;
                if (consume)
                begin
                    if (op_reg == laqs_pkg::REQ_DISPLAY)
                    begin
                        emit        = 1'b1;
                        status_next = laqs_pkg::ST_OK;
                        word_next   = rd_data_reg;
                        slot_next   = laqs_pkg::SLOT_W'(data_idx_reg);
                        last_next   = (data_idx_reg + CW'(1) == tail_reg);
                    end
                    else if (rd_data_reg == key_reg)
                    begin
                        // A new match lets the one held back go out as not final.
                        if (pend_vld_reg)
                        begin
                            emit        = 1'b1;
                            status_next = laqs_pkg::ST_FOUND;
                            word_next   = key_reg;
                            slot_next   = laqs_pkg::SLOT_W'(pend_slot_reg);
                            last_next   = 1'b0;
                        end
                        pend_vld_next  = 1'b1;
                        pend_slot_next = data_idx_reg;
                    end
                end

                // The read register is refilled only when its word has been retired.
                issue = (idx_reg < tail_reg) && (!data_vld_reg || consume);
                if (issue)
                begin
                    rd_en         = 1'b1;
                    idx_next      = idx_reg + CW'(1);
                    data_idx_next = idx_reg;
                    data_vld_next = 1'b1;
                end
                else if (consume)
                begin
                    data_vld_next = 1'b0;
                end

                if ((idx_reg >= tail_reg) && (!data_vld_reg || consume))
                begin
                    if (op_reg == laqs_pkg::REQ_DISPLAY)
                    begin
                        state_next = laqs_pkg::S_IDLE;
                    end
                    else
                    begin
                        state_next = laqs_pkg::S_FLUSH;
                    end
                end
            end

            laqs_pkg::S_FLUSH:
            begin
                // Final search result: the held match, or not found.
                if (out_free)
                begin
                    emit      = 1'b1;
                    last_next = 1'b1;
                    if (pend_vld_reg)
                    begin
                        status_next = laqs_pkg::ST_FOUND;
                        word_next   = key_reg;
                        slot_next   = laqs_pkg::SLOT_W'(pend_slot_reg);
                    end
                    else
                    begin
                        status_next = laqs_pkg::ST_NOTFOUND;
                        word_next   = '0;
                        slot_next   = '0;
                    end
                    pend_vld_next = 1'b0;
                    state_next    = laqs_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = laqs_pkg::S_IDLE;
            end
        endcase

        out_valid_next = emit ? 1'b1 : (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= laqs_pkg::S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            data_vld_reg  <= 1'b0;
            pend_vld_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            data_vld_reg  <= data_vld_next;
            pend_vld_reg  <= pend_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        key_reg       <= key_next;
        idx_reg       <= idx_next;
        data_idx_reg  <= data_idx_next;
        pend_slot_reg <= pend_slot_next;
        status_reg    <= status_next;
        word_reg      <= word_next;
        slot_reg      <= slot_next;
        last_reg      <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign word_out  = word_reg;
    assign slot      = slot_reg;
    assign last      = last_reg;

    // A result that is not final only comes from a walk that is still in progress.
    a_not_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !last_reg) |-> (state_reg != laqs_pkg::S_IDLE))
        else $error("non-final result shown while idle");

    // The head never passes the tail, and the tail never passes the depth.
    a_ptr_order: assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg <= tail_reg) && (tail_reg <= DEPTH_C))
        else $error("queue pointers out of order");

    // A walk read only touches live, written slots.
    a_walk_read: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_en && (state_reg == laqs_pkg::S_WALK)) |-> (idx_reg < tail_reg))
        else $error("walk read beyond tail");

    // A new result is never loaded over one that has not been taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> out_free)
        else $error("result overwritten before it was taken");

    // An insert that writes the memory moves the tail by exactly one.
    a_insert_tail: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> (tail_reg == $past(tail_reg) + CW'(1)))
        else $error("insert did not advance the tail");

endmodule

`default_nettype wire

// File: sim/tb_linear_array_queue_with_search_core.sv
`timescale 1ns / 1ps

module tb_linear_array_queue_with_search_core;

    // The queue is checked at its full default depth.
    localparam int DEPTH = 64;
    localparam int CLK_HALF = 6;

    // The random part follows a short directed table, for about 310 requests in all.
    localparam int RANDOM_COUNT = 286;

    // The receiver holds off for this many cycles once, while the sender keeps offering
    // requests back to back, so that the block fills up and stalls its input.
    localparam int LONG_HOLD = 250;
    localparam int HOLD_START = 90;
    localparam int HOLD_BURST = 10;

    // At this point in the random part the sender stops until every result has come back.
    localparam int PAUSE_AT = 180;

    // The last stretch of the run has no idling on either side.
    localparam int CALM_COUNT = 40;

    // The slowest correct run is roughly 310 requests, each with 64 results that each wait
    // out the longest random receiver stall, plus sender gaps. The limit is several times that.
    localparam int CYCLE_LIMIT = 1500000;

    // One result of the block, as the predictor expects it.
    typedef struct {
        laqs_pkg::status_t                   status;
        logic signed [laqs_pkg::WORD_W-1:0]  word;
        logic [laqs_pkg::SLOT_W-1:0]         slot;
        logic                                last;
    } result_t;

    // One row of the directed table. Where typed is set, the single expected result is
    // written into the row; otherwise the predictor supplies the results.
    typedef struct {
        laqs_pkg::req_t                      req;
        logic signed [laqs_pkg::WORD_W-1:0]  word;
        bit                                  typed;
        result_t                             res;
    } stim_row_t;

    logic                                clk = 1'b0;
    logic                                rst_n;
    logic                                in_valid;
    logic                                in_ready;
    logic [1:0]                          req_type;
    logic signed [laqs_pkg::WORD_W-1:0]  word_in;
    logic                                out_valid;
    logic                                out_ready;
    logic [2:0]                          status;
    logic signed [laqs_pkg::WORD_W-1:0]  word_out;
    logic [laqs_pkg::SLOT_W-1:0]         slot;
    logic                                last;

    // Predictor state: a private copy of the array, the head and the tail.
    logic signed [laqs_pkg::WORD_W-1:0]  q_store [DEPTH];
    logic [6:0]                          q_head;
    logic [6:0]                          q_tail;

    // Results that one request causes, then the queue of all results still awaited.
    result_t                             step_results[$];
    result_t                             awaited_results[$];

    stim_row_t                           directed_rows[$];
    logic signed [laqs_pkg::WORD_W-1:0]  word_pool [6];

    int                                  mismatches = 0;
    int                                  cycle_count = 0;
    bit                                  calm = 1'b0;
    bit                                  sink_hold_req = 1'b0;

    always #(CLK_HALF) clk = ~clk;

    linear_array_queue_with_search_core #(
        .DEPTH(DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .req_type (req_type),
        .word_in  (word_in),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .status   (status),
        .word_out (word_out),
        .slot     (slot),
        .last     (last)
    );

    function automatic result_t make_result(input laqs_pkg::status_t st,
                                            input logic signed [laqs_pkg::WORD_W-1:0] w,
                                            input int idx, input logic lst);
        result_t r;
        r.status = st;
        r.word   = w;
        r.slot   = idx[laqs_pkg::SLOT_W-1:0];
        r.last   = lst;
        return r;
    endfunction

    // Works out the results of one accepted request and updates the private queue state.
    // The live entries are those from the head up to one below the tail.
    function automatic void predict_request(input laqs_pkg::req_t req,
                                            input logic signed [laqs_pkg::WORD_W-1:0] w);
        int match_count;
        int seen;
        int i;
        step_results.delete();
        match_count = 0;
        seen = 0;
        if (req == laqs_pkg::REQ_INSERT)
        begin
            // Slots are never reclaimed, so a tail at the depth means overflow until reset.
            if (q_tail >= DEPTH)
            begin
                step_results.push_back(make_result(laqs_pkg::ST_OVERFLOW, '0, 0, 1'b1));
            end
            else
            begin
                q_store[q_tail[5:0]] = w;
                q_tail++;
                step_results.push_back(make_result(laqs_pkg::ST_OK, '0, 0, 1'b1));
            end
        end
        else if (q_head >= q_tail)
        begin
            // Delete, search and display on an empty queue all report underflow.
            step_results.push_back(make_result(laqs_pkg::ST_UNDERFLOW, '0, 0, 1'b1));
        end
        else if (req == laqs_pkg::REQ_DELETE)
        begin
            step_results.push_back(make_result(laqs_pkg::ST_OK, q_store[q_head[5:0]],
                                               q_head, 1'b1));
            q_head++;
        end
        else if (req == laqs_pkg::REQ_SEARCH)
        begin
            for (i = q_head; i < q_tail; i++)
            begin
                if (q_store[i] == w)
                begin
                    match_count++;
                end
            end
            if (match_count == 0)
            begin
                step_results.push_back(make_result(laqs_pkg::ST_NOTFOUND, '0, 0, 1'b1));
            end
            else
            begin
                for (i = q_head; i < q_tail; i++)
                begin
                    if (q_store[i] == w)
                    begin
                        seen++;
                        step_results.push_back(make_result(laqs_pkg::ST_FOUND, w, i,
                                                           seen == match_count));
                    end
                end
            end
        end
        else
        begin
            for (i = q_head; i < q_tail; i++)
            begin
                step_results.push_back(make_result(laqs_pkg::ST_OK, q_store[i], i,
                                                   i + 1 == q_tail));
            end
        end
    endfunction

    function automatic void add_row(input laqs_pkg::req_t req,
                                    input logic signed [laqs_pkg::WORD_W-1:0] w,
                                    input bit typed, input laqs_pkg::status_t st,
                                    input logic signed [laqs_pkg::WORD_W-1:0] ow,
                                    input int sl);
        stim_row_t row;
        row.req   = req;
        row.word  = w;
        row.typed = typed;
        row.res   = make_result(st, ow, sl, 1'b1);
        directed_rows.push_back(row);
    endfunction

    // Random request mix. While slots remain, inserts dominate so that the array fills
    // and long searches and displays get exercised; once full, the mix turns to reads,
    // deletes and the odd overflowing insert.
    function automatic laqs_pkg::req_t pick_request();
        int roll;
        roll = $urandom_range(0, 99);
        if (q_tail < DEPTH)
        begin
            if (roll < 45) return laqs_pkg::REQ_INSERT;
            if (roll < 60) return laqs_pkg::REQ_DELETE;
            if (roll < 85) return laqs_pkg::REQ_SEARCH;
            return laqs_pkg::REQ_DISPLAY;
        end
        if (roll < 10) return laqs_pkg::REQ_INSERT;
        if (roll < 40) return laqs_pkg::REQ_DELETE;
        if (roll < 80) return laqs_pkg::REQ_SEARCH;
        return laqs_pkg::REQ_DISPLAY;
    endfunction

    // Inserted words often come from a small pool so that searches find several matches.
    // Search keys are mostly live entries, so that most searches hit.
    function automatic logic signed [laqs_pkg::WORD_W-1:0] pick_word(input laqs_pkg::req_t req);
        int roll;
        roll = $urandom_range(0, 99);
        if (req == laqs_pkg::REQ_INSERT && roll < 40)
        begin
            return word_pool[$urandom_range(0, 5)];
        end
        if (req == laqs_pkg::REQ_SEARCH)
        begin
            if (roll < 55 && q_head < q_tail)
            begin
                return q_store[$urandom_range(int'(q_head), int'(q_tail) - 1)];
            end
            if (roll < 80)
            begin
                return word_pool[$urandom_range(0, 5)];
            end
        end
        return $urandom;
    endfunction

    // Offers one request, holds it until accepted, then records what it should cause.
    // It returns in the time step of the accepting edge, with valid still high.
    task automatic issue_request(input laqs_pkg::req_t req,
                                 input logic signed [laqs_pkg::WORD_W-1:0] w,
                                 input bit typed, input result_t typed_res);
        in_valid <= 1'b1;
        req_type <= req;
        word_in  <= w;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        predict_request(req, w);
        if (typed)
        begin
            awaited_results.push_back(typed_res);
        end
        else
        begin
            foreach (step_results[j])
            begin
                awaited_results.push_back(step_results[j]);
            end
        end
    endtask

    // Sender idling. Every fourth stretch of 25 requests runs with no gaps at all.
    task automatic idle_gap(input int k);
        if (!calm && ((k / 25) % 4) != 3 && $urandom_range(0, 2) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
    endtask

    // Lowers valid, then waits on clock edges until every result has come back.
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (awaited_results.size() != 0);
    endtask

    initial
    begin : stimulus
        laqs_pkg::req_t                     req;
        logic signed [laqs_pkg::WORD_W-1:0] w;
        result_t                            unused;
        in_valid = 1'b0;
        req_type = laqs_pkg::REQ_INSERT;
        word_in  = '0;
        rst_n    = 1'b0;
        q_head   = '0;
        q_tail   = '0;
        unused   = make_result(laqs_pkg::ST_OK, '0, 0, 1'b1);

        word_pool[0] = 32'sh7FFF_FFFF;
        word_pool[1] = 32'sh8000_0000;
        word_pool[2] = '0;
        word_pool[3] = -32'sd1;
        word_pool[4] = $urandom;
        word_pool[5] = $urandom;

        // Every read request on a fresh queue reports underflow.
        add_row(laqs_pkg::REQ_DELETE,  32'sh0,         1'b1, laqs_pkg::ST_UNDERFLOW, 0, 0);
        add_row(laqs_pkg::REQ_SEARCH,  32'sh0,         1'b1, laqs_pkg::ST_UNDERFLOW, 0, 0);
        add_row(laqs_pkg::REQ_DISPLAY, 32'sh0,         1'b1, laqs_pkg::ST_UNDERFLOW, 0, 0);
        // Extreme words, with one duplicate for a multi-match search.
        add_row(laqs_pkg::REQ_INSERT,  32'sh7FFF_FFFF, 1'b1, laqs_pkg::ST_OK, 0, 0);
        add_row(laqs_pkg::REQ_INSERT,  32'sh8000_0000, 1'b1, laqs_pkg::ST_OK, 0, 0);
        add_row(laqs_pkg::REQ_INSERT,  32'sh0,         1'b1, laqs_pkg::ST_OK, 0, 0);
        add_row(laqs_pkg::REQ_INSERT,  -32'sd1,        1'b1, laqs_pkg::ST_OK, 0, 0);
        add_row(laqs_pkg::REQ_INSERT,  32'sh8000_0000, 1'b1, laqs_pkg::ST_OK, 0, 0);
        add_row(laqs_pkg::REQ_DISPLAY, 32'sh5A5A_5A5A, 1'b0, laqs_pkg::ST_OK, 0, 0);
        add_row(laqs_pkg::REQ_SEARCH,  32'sh8000_0000, 1'b0, laqs_pkg::ST_OK, 0, 0);
        add_row(laqs_pkg::REQ_SEARCH,  32'sh1234_5678, 1'b1, laqs_pkg::ST_NOTFOUND, 0, 0);
        add_row(laqs_pkg::REQ_SEARCH,  -32'sd1,        1'b0, laqs_pkg::ST_OK, 0, 0);
        add_row(laqs_pkg::REQ_DELETE,  32'shFFFF_FFFF, 1'b1, laqs_pkg::ST_OK,
                32'sh7FFF_FFFF, 0);
        add_row(laqs_pkg::REQ_DELETE,  32'sh0,         1'b1, laqs_pkg::ST_OK,
                32'sh8000_0000, 1);
        // A deleted word is no longer live, so searching for it finds nothing.
        add_row(laqs_pkg::REQ_SEARCH,  32'sh7FFF_FFFF, 1'b1, laqs_pkg::ST_NOTFOUND, 0, 0);
        add_row(laqs_pkg::REQ_DISPLAY, 32'sh0,         1'b0, laqs_pkg::ST_OK, 0, 0);
        add_row(laqs_pkg::REQ_DELETE,  32'sh0,         1'b0, laqs_pkg::ST_OK, 0, 0);
        add_row(laqs_pkg::REQ_DELETE,  32'sh0,         1'b0, laqs_pkg::ST_OK, 0, 0);
        add_row(laqs_pkg::REQ_DELETE,  32'sh0,         1'b0, laqs_pkg::ST_OK, 0, 0);
        // Drained by deletes, the queue is empty again with the head past slot zero.
        add_row(laqs_pkg::REQ_DELETE,  32'sh0,         1'b1, laqs_pkg::ST_UNDERFLOW, 0, 0);
        add_row(laqs_pkg::REQ_SEARCH,  32'sh0,         1'b1, laqs_pkg::ST_UNDERFLOW, 0, 0);
        add_row(laqs_pkg::REQ_DISPLAY, 32'sh0,         1'b1, laqs_pkg::ST_UNDERFLOW, 0, 0);
        add_row(laqs_pkg::REQ_INSERT,  32'sh5555_5555, 1'b1, laqs_pkg::ST_OK, 0, 0);
        add_row(laqs_pkg::REQ_SEARCH,  32'sh5555_5555, 1'b0, laqs_pkg::ST_OK, 0, 0);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            issue_request(directed_rows[i].req, directed_rows[i].word,
                          directed_rows[i].typed, directed_rows[i].res);
            idle_gap(i);
        end
        wait_drained();

        for (int k = 0; k < RANDOM_COUNT; k++)
        begin
            if (k == RANDOM_COUNT - CALM_COUNT)
            begin
                calm = 1'b1;
            end
            if (k == HOLD_START)
            begin
                sink_hold_req = 1'b1;
            end
            if (k == PAUSE_AT)
            begin
                wait_drained();
            end
            req = pick_request();
            w = pick_word(req);
            issue_request(req, w, 1'b0, unused);
            // During the long receiver hold the requests come back to back.
            if (k < HOLD_START || k >= HOLD_START + HOLD_BURST)
            begin
                idle_gap(k);
            end
        end

        // Wait for the last results, then a little longer to catch any stray result.
        wait_drained();
        repeat (DEPTH + 8) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("linear_array_queue_with_search_core verification clean");
        end
        else
        begin
            $display("linear_array_queue_with_search_core verification failed");
        end
        $finish;
    end

    // Receiver pacing: random stall bursts, stretches of steady readiness, one long hold
    // on request from the stimulus, and no stalls at all in the calm final stretch.
    initial
    begin : sink_pacing
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (sink_hold_req)
            begin
                out_ready <= 1'b0;
                for (int n = 0; n < LONG_HOLD; n++)
                begin
                    @(posedge clk);
                end
                sink_hold_req = 1'b0;
            end
            else if (!calm && $urandom_range(0, 2) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                if (calm)
                begin
                    @(posedge clk);
                end
                else
                begin
                    repeat ($urandom_range(1, 20)) @(posedge clk);
                end
            end
        end
    end

    // Each accepted result is compared field by field with the oldest awaited one.
    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (awaited_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual status %0d word %0d",
                         $time, status, word_out);
                mismatches++;
            end
            else
            begin
                want = awaited_results.pop_front();
                if (status !== want.status)
                begin
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, want.status, status);
                    mismatches++;
                end
                if (word_out !== want.word)
                begin
                    $display("%0t: word_out mismatch, expected %0d, actual %0d",
                             $time, want.word, word_out);
                    mismatches++;
                end
                if (slot !== want.slot)
                begin
                    $display("%0t: slot mismatch, expected %0d, actual %0d",
                             $time, want.slot, slot);
                    mismatches++;
                end
                if (last !== want.last)
                begin
                    $display("%0t: last mismatch, expected %0d, actual %0d",
                             $time, want.last, last);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("linear_array_queue_with_search_core verification failed");
            $finish;
        end
    end

endmodule

// File: files.f
hw/rtl/laqs_pkg.sv
hw/rtl/linear_array_queue_with_search_core.sv
sim/tb_linear_array_queue_with_search_core.sv
